// ----- rtl/fcp_pkg.sv -----
// ----------------------------------------------------------------------------
// fcp_pkg
// Types, constants and arithmetic helpers shared by the dq current loop.
// ----------------------------------------------------------------------------
`default_nettype none

package fcp_pkg;

    // Sine table geometry: the table holds one quarter wave, 0..pi/2 inclusive.
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam int SINE_QTR   = SINE_DEPTH / 4;
    localparam int QTR_W      = SINE_IDX_W - 2;

    localparam longint HALF_PI_Q30   = 64'd1686629713;
    localparam int     INV_SQRT3_Q15 = 18919;

    // Multiplier operand widths and product width.
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 58;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_PROP_GAIN     = 2'd0,
        CFG_INTEGRAL_GAIN = 2'd1,
        CFG_CURRENT_LIMIT = 2'd2,
        CFG_VOLTAGE_LIMIT = 2'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [23:0] prop_gain;
        logic [23:0] integral_gain;
        logic [14:0] current_limit;
        logic [14:0] voltage_limit;
    } cfg_t;

    typedef struct packed {
        logic        run_enable;
        logic [15:0] timestep;
        logic [15:0] q_reference;
        logic [15:0] d_reference;
        logic [15:0] electrical_angle;
        logic [15:0] phase_b_current;
        logic [15:0] phase_a_current;
    } in_item_t;

    typedef struct packed {
        logic [15:0] q_voltage;
        logic [15:0] d_voltage;
        logic [15:0] q_current;
        logic [15:0] d_current;
    } out_item_t;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_SIN, ST_COS, ST_KIDT, ST_ID1, ST_ID2, ST_IQ1, ST_IQ2, ST_IQ3,
        ST_CLEAR, ST_ERRQ, ST_IDA, ST_IDB, ST_IQA, ST_IQB, ST_PD, ST_PQ, ST_VQ,
        ST_M1, ST_M2, ST_M3, ST_CMP, ST_SQRT, ST_SQFIX, ST_NUMD, ST_NUMQ, ST_DIV,
        ST_DFIN, ST_DONE
    } state_e;

    // Operand pair presented to the shared multiplier.
    typedef enum logic [4:0] {
        MUL_NONE, MUL_BETA, MUL_KIDT, MUL_ALPHA_C, MUL_BETA_S, MUL_BETA_C,
        MUL_ALPHA_S, MUL_KHI_ED, MUL_KLO_ED, MUL_KHI_EQ, MUL_KLO_EQ, MUL_KP_ED,
        MUL_KP_EQ, MUL_VD_VD, MUL_VQ_VQ, MUL_VL_VL, MUL_VD_VL, MUL_VQ_VL
    } mul_sel_e;

    // What the accumulator does with the registered product.
    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD, ACC_LOAD_HI, ACC_ADD, ACC_SUB
    } acc_op_e;

    // Which datapath registers are updated.
    typedef enum logic [4:0] {
        WR_NONE, WR_LOAD, WR_SIN, WR_COS_BETA, WR_KIDT, WR_ID, WR_IQ_ED, WR_EQ,
        WR_CLEAR, WR_DI, WR_QI, WR_VD, WR_VQ, WR_MAG, WR_SQRT, WR_SQFIX,
        WR_NUMD, WR_NUMQ, WR_DIV, WR_DFIN, WR_OUT
    } wr_op_e;

    typedef struct packed {
        mul_sel_e    mul;
        acc_op_e     acc;
        wr_op_e      wr;
        logic [3:0]  iter;
    } cmd_t;

    typedef struct packed {
        logic loop_run;
        logic need_scale;
    } stat_t;

    // Round to nearest, ties away from zero, then shift right by s.
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned s);
        logic signed [63:0] h;
        h = 64'sd1 <<< (s - 1);
        if (v < 0)
            return (v + h - 64'sd1) >>> s;
        else
            return (v + h) >>> s;
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
        if (v > lim)
            return lim;
        else if (v < -lim)
            return -lim;
        else
            return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        else if (v < -64'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // Quarter-wave sine by a Taylor series; evaluated at elaboration only.
    function automatic logic [14:0] quarter_sine(input int unsigned m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (64'(m) * 64'(HALF_PI_Q30)) / SINE_QTR;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        term = ((term * x2) >> 30) / 6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 72;
        sum  = sum + signed'(term);
        if (sum < 0)
            sum = 0;
        r = ((sum <<< 15) + (64'sd1 <<< 29)) >>> 30;
        if (r > 64'sd32767)
            r = 64'sd32767;
        return r[14:0];
    endfunction

    typedef logic [14:0] qrom_t [SINE_QTR + 1];

    function automatic qrom_t build_qrom();
        qrom_t t;
        for (int k = 0; k <= SINE_QTR; k++)
        begin
            t[k] = quarter_sine(k);
        end
        return t;
    endfunction

    localparam qrom_t QROM = build_qrom();

    // Full-turn sine from the quarter table.
    function automatic logic signed [15:0] sine_lookup(input logic [SINE_IDX_W-1:0] k);
        logic [1:0]       quad;
        logic [QTR_W:0]   rr;
        logic signed [15:0] mag;
        quad = k[SINE_IDX_W-1:SINE_IDX_W-2];
        rr   = quad[0] ? ((QTR_W+1)'(SINE_QTR) - {1'b0, k[QTR_W-1:0]})
                       : {1'b0, k[QTR_W-1:0]};
        mag  = signed'({1'b0, QROM[rr]});
        return quad[1] ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/foc_dq_current_pi_loop_core.sv -----
// ----------------------------------------------------------------------------
// foc_dq_current_pi_loop_core
// Field-oriented dq current loop: Clarke and Park transforms followed by
// two PI regulators with integrator, output and vector-magnitude limits.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters on the s_axis channel (currents, angle, references,
//   timestep in tdata, run flag in tuser); one result leaves on m_axis
//   with the measured dq currents and the dq voltage commands.
//   Gains and limits are set through the cfg write port while the block
//   is idle; a write takes effect at the clock edge that carries it.
// Timing:
//   One item at a time through a single shared 25x18 multiplier.
//   A stopped loop, a running loop within the magnitude limit and a running
//   loop whose vector is scaled down take successively longer paths; the
//   last adds 16 square-root steps and 16 divide steps.
//   s_axis_tready returns in the same cycle that the result is posted.
// Reset and stall:
//   Reset clears the integrators and sets the gains to zero and both limits
//   to full scale. A result waiting on m_axis does not block the next
//   transfer in; the next result waits until the pending one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module foc_dq_current_pi_loop_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // phase_a_current, phase_b_current, electrical_angle, d_reference,
    // q_reference, timestep (16 bits each, from bit 0 up)
    input  wire logic [95:0] s_axis_tdata,
    // run_enable
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // d_current, q_current, d_voltage, q_voltage (16 bits each, from bit 0 up)
    output logic [63:0]      m_axis_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);
    import fcp_pkg::*;

    cfg_t      cfg_reg;
    cmd_t      cmd;
    stat_t     stat;
    in_item_t  item;
    out_item_t result;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain     <= '0;
            cfg_reg.integral_gain <= '0;
            cfg_reg.current_limit <= '1;
            cfg_reg.voltage_limit <= '1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_e'(cfg_index))
                CFG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_wdata;
                CFG_INTEGRAL_GAIN: cfg_reg.integral_gain <= cfg_wdata;
                CFG_CURRENT_LIMIT: cfg_reg.current_limit <= cfg_wdata[14:0];
                CFG_VOLTAGE_LIMIT: cfg_reg.voltage_limit <= cfg_wdata[14:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Unpack the input transfer.
    assign item = {s_axis_tuser, s_axis_tdata};

    fcp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fcp_dp u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .item   (item),
        .stat   (stat),
        .result (result)
    );

    assign m_axis_tdata = result;

    // The sequencer is busy right after taking an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    // Posting a result returns the sequencer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result posted without returning to idle");

    // Voltage commands never exceed the voltage limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(result.d_voltage) <= $signed({1'b0, cfg_reg.voltage_limit}) &&
             $signed(result.d_voltage) >= -$signed({1'b0, cfg_reg.voltage_limit}) &&
             $signed(result.q_voltage) <= $signed({1'b0, cfg_reg.voltage_limit}) &&
             $signed(result.q_voltage) >= -$signed({1'b0, cfg_reg.voltage_limit})))
        else $error("voltage command beyond limit");

endmodule

`default_nettype wire

// ----- rtl/fcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// fcp_ctrl
// Sequencer for the dq current loop: steps the datapath through the
// transforms, PI updates and vector limit, and owns the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire fcp_pkg::stat_t stat,
    output fcp_pkg::cmd_t       cmd
);
    import fcp_pkg::*;

    state_e      state_reg;
    state_e      state_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // State and iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SIN;
            ST_SIN:    state_next = ST_COS;
            ST_COS:    state_next = ST_KIDT;
            ST_KIDT:   state_next = ST_ID1;
            ST_ID1:    state_next = ST_ID2;
            ST_ID2:    state_next = ST_IQ1;
            ST_IQ1:    state_next = ST_IQ2;
            ST_IQ2:    state_next = ST_IQ3;
            ST_IQ3:    state_next = stat.loop_run ? ST_ERRQ : ST_CLEAR;
            ST_CLEAR:  state_next = ST_DONE;
            ST_ERRQ:   state_next = ST_IDA;
            ST_IDA:    state_next = ST_IDB;
            ST_IDB:    state_next = ST_IQA;
            ST_IQA:    state_next = ST_IQB;
            ST_IQB:    state_next = ST_PD;
            ST_PD:     state_next = ST_PQ;
            ST_PQ:     state_next = ST_VQ;
            ST_VQ:     state_next = ST_M1;
            ST_M1:     state_next = ST_M2;
            ST_M2:     state_next = ST_M3;
            ST_M3:     state_next = ST_CMP;
            ST_CMP:    state_next = stat.need_scale ? ST_SQRT : ST_DONE;
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_SQFIX;
            end
            ST_SQFIX:  state_next = ST_NUMD;
            ST_NUMD:   state_next = ST_NUMQ;
            ST_NUMQ:   state_next = ST_DIV;
            ST_DIV:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = ST_DFIN;
            end
            ST_DFIN:   state_next = ST_DONE;
            ST_DONE:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb
    begin
        cmd.mul        = MUL_NONE;
        cmd.acc        = ACC_HOLD;
        cmd.wr         = WR_NONE;
        cmd.iter       = cnt_reg;
        in_ready       = 1'b0;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.wr = WR_LOAD;
            end
            ST_SIN:   begin cmd.wr = WR_SIN;      cmd.mul = MUL_BETA;    end
            ST_COS:   begin cmd.wr = WR_COS_BETA; cmd.mul = MUL_KIDT;    end
            ST_KIDT:  begin cmd.wr = WR_KIDT;     cmd.mul = MUL_ALPHA_C; end
            ST_ID1:   begin cmd.acc = ACC_LOAD;   cmd.mul = MUL_BETA_S;  end
            ST_ID2:   begin cmd.acc = ACC_ADD;    cmd.mul = MUL_BETA_C;  end
            ST_IQ1:
            begin
                cmd.wr  = WR_ID;
                cmd.acc = ACC_LOAD;
                cmd.mul = MUL_ALPHA_S;
            end
            ST_IQ2:   cmd.acc = ACC_SUB;
            ST_IQ3:   cmd.wr = WR_IQ_ED;
            ST_CLEAR: cmd.wr = WR_CLEAR;
            ST_ERRQ:  begin cmd.wr = WR_EQ;         cmd.mul = MUL_KHI_ED; end
            ST_IDA:   begin cmd.acc = ACC_LOAD_HI;  cmd.mul = MUL_KLO_ED; end
            ST_IDB:   begin cmd.acc = ACC_ADD;      cmd.mul = MUL_KHI_EQ; end
            ST_IQA:
            begin
                cmd.wr  = WR_DI;
                cmd.acc = ACC_LOAD_HI;
                cmd.mul = MUL_KLO_EQ;
            end
            ST_IQB:   begin cmd.acc = ACC_ADD;      cmd.mul = MUL_KP_ED;  end
            ST_PD:
            begin
                cmd.wr  = WR_QI;
                cmd.acc = ACC_LOAD;
                cmd.mul = MUL_KP_EQ;
            end
            ST_PQ:    begin cmd.wr = WR_VD; cmd.acc = ACC_LOAD; end
            ST_VQ:    cmd.wr = WR_VQ;
            ST_M1:    cmd.mul = MUL_VD_VD;
            ST_M2:    begin cmd.acc = ACC_LOAD; cmd.mul = MUL_VQ_VQ; end
            ST_M3:    begin cmd.acc = ACC_ADD;  cmd.mul = MUL_VL_VL; end
            ST_CMP:   cmd.wr = WR_MAG;
            ST_SQRT:  cmd.wr = WR_SQRT;
            ST_SQFIX: begin cmd.wr = WR_SQFIX; cmd.mul = MUL_VD_VL; end
            ST_NUMD:  begin cmd.wr = WR_NUMD;  cmd.mul = MUL_VQ_VL; end
            ST_NUMQ:  cmd.wr = WR_NUMQ;
            ST_DIV:   cmd.wr = WR_DIV;
            ST_DFIN:  cmd.wr = WR_DFIN;
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.wr         = WR_OUT;
                    out_valid_next = 1'b1;
                end
            end
            default:  cmd.wr = WR_NONE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/fcp_dp.sv -----
// ----------------------------------------------------------------------------
// fcp_dp
// Datapath of the dq current loop: one shared multiplier with accumulator,
// sine table, integrators, a bit-serial square root and two serial dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module fcp_dp
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fcp_pkg::cmd_t      cmd,
    input  wire fcp_pkg::cfg_t      cfg,
    input  wire fcp_pkg::in_item_t  item,
    output fcp_pkg::stat_t          stat,
    output fcp_pkg::out_item_t      result
);
    import fcp_pkg::*;

    // Latched item.
    logic signed [15:0]          alpha_reg;
    logic signed [17:0]          ab_reg;
    logic [SINE_IDX_W-1:0]       idx_reg;
    logic signed [15:0]          dref_reg;
    logic signed [15:0]          qref_reg;
    logic [15:0]                 dt_reg;
    logic                        run_reg;

    // Working registers.
    logic signed [15:0]          s_reg;
    logic signed [15:0]          c_reg;
    logic signed [16:0]          beta_reg;
    logic [39:0]                 kidt_reg;
    logic signed [15:0]          id_reg;
    logic signed [15:0]          iq_reg;
    logic signed [16:0]          ed_reg;
    logic signed [16:0]          eq_reg;
    logic signed [15:0]          di_reg;
    logic signed [15:0]          qi_reg;
    logic signed [15:0]          vd_reg;
    logic signed [15:0]          vq_reg;
    logic signed [MUL_P_W-1:0]   mul_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [31:0]                 n_reg;
    logic [31:0]                 res_reg;
    logic [15:0]                 m_reg;
    logic                        negd_reg;
    logic                        negq_reg;
    logic [30:0]                 remd_reg;
    logic [30:0]                 remq_reg;
    logic [15:0]                 qd_reg;
    logic [15:0]                 qq_reg;
    out_item_t                   out_reg;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [63:0]          acc64;
    logic signed [63:0]          il64;
    logic signed [63:0]          vl64;
    logic signed [15:0]          sat_rnd15;
    logic signed [16:0]          err_d;
    logic signed [16:0]          err_q;
    logic signed [15:0]          integ_d;
    logic signed [15:0]          integ_q;
    logic signed [15:0]          volt_d;
    logic signed [15:0]          volt_q;
    logic [31:0]                 sq_bit;
    logic [31:0]                 sq_trial;
    logic [30:0]                 dsh;
    logic [31:0]                 numq_mag;
    logic [3:0]                  pos;

    assign acc64 = 64'(acc_reg);
    assign il64  = signed'(64'(cfg.current_limit));
    assign vl64  = signed'(64'(cfg.voltage_limit));
    assign pos   = 4'd15 - cmd.iter;

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_BETA:    begin mul_a = MUL_A_W'(INV_SQRT3_Q15);  mul_b = ab_reg; end
            MUL_KIDT:
            begin
                mul_a = signed'({1'b0, cfg.integral_gain});
                mul_b = signed'({2'b00, dt_reg});
            end
            MUL_ALPHA_C: begin mul_a = MUL_A_W'(alpha_reg); mul_b = MUL_B_W'(c_reg); end
            MUL_BETA_S:  begin mul_a = MUL_A_W'(beta_reg);  mul_b = MUL_B_W'(s_reg); end
            MUL_BETA_C:  begin mul_a = MUL_A_W'(beta_reg);  mul_b = MUL_B_W'(c_reg); end
            MUL_ALPHA_S: begin mul_a = MUL_A_W'(alpha_reg); mul_b = MUL_B_W'(s_reg); end
            MUL_KHI_ED:
            begin
                mul_a = signed'(MUL_A_W'(kidt_reg[39:24]));
                mul_b = MUL_B_W'(ed_reg);
            end
            MUL_KLO_ED:
            begin
                mul_a = signed'({1'b0, kidt_reg[23:0]});
                mul_b = MUL_B_W'(ed_reg);
            end
            MUL_KHI_EQ:
            begin
                mul_a = signed'(MUL_A_W'(kidt_reg[39:24]));
                mul_b = MUL_B_W'(eq_reg);
            end
            MUL_KLO_EQ:
            begin
                mul_a = signed'({1'b0, kidt_reg[23:0]});
                mul_b = MUL_B_W'(eq_reg);
            end
            MUL_KP_ED:
            begin
                mul_a = signed'({1'b0, cfg.prop_gain});
                mul_b = MUL_B_W'(ed_reg);
            end
            MUL_KP_EQ:
            begin
                mul_a = signed'({1'b0, cfg.prop_gain});
                mul_b = MUL_B_W'(eq_reg);
            end
            MUL_VD_VD:   begin mul_a = MUL_A_W'(vd_reg); mul_b = MUL_B_W'(vd_reg); end
            MUL_VQ_VQ:   begin mul_a = MUL_A_W'(vq_reg); mul_b = MUL_B_W'(vq_reg); end
            MUL_VL_VL:
            begin
                mul_a = signed'(MUL_A_W'(cfg.voltage_limit));
                mul_b = signed'(MUL_B_W'(cfg.voltage_limit));
            end
            MUL_VD_VL:
            begin
                mul_a = MUL_A_W'(vd_reg);
                mul_b = signed'(MUL_B_W'(cfg.voltage_limit));
            end
            MUL_VQ_VL:
            begin
                mul_a = MUL_A_W'(vq_reg);
                mul_b = signed'(MUL_B_W'(cfg.voltage_limit));
            end
            default:     begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Rounding, clamping and limit arithmetic on the accumulator.
    always_comb
    begin
        sat_rnd15 = sat16(rnd_shift(acc64, 15));
        err_d     = 17'(clamp64(64'(dref_reg), il64) - 64'(id_reg));
        err_q     = 17'(clamp64(64'(qref_reg), il64) - 64'(iq_reg));
        integ_d   = 16'(clamp64(64'(di_reg) + rnd_shift(acc64, 28), vl64));
        integ_q   = 16'(clamp64(64'(qi_reg) + rnd_shift(acc64, 28), vl64));
        volt_d    = 16'(clamp64(rnd_shift(acc64, 12) + 64'(di_reg), vl64));
        volt_q    = 16'(clamp64(rnd_shift(acc64, 12) + 64'(qi_reg), vl64));
        sq_bit    = 32'd1 << {pos, 1'b0};
        sq_trial  = res_reg + sq_bit;
        dsh       = 31'(m_reg) << pos;
        numq_mag  = mul_reg[MUL_P_W-1] ? 32'(-mul_reg) : 32'(mul_reg);
    end

    assign stat.loop_run   = run_reg;
    assign stat.need_scale = acc64 > 64'(mul_reg);

    // Multiplier product register and accumulator.
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
        case (cmd.acc)
            ACC_LOAD:    acc_reg <= ACC_W'(mul_reg);
            ACC_LOAD_HI: acc_reg <= ACC_W'(mul_reg) <<< 24;
            ACC_ADD:     acc_reg <= acc_reg + ACC_W'(mul_reg);
            ACC_SUB:     acc_reg <= acc_reg - ACC_W'(mul_reg);
            default:     acc_reg <= acc_reg;
        endcase
    end

    // Integrators: the only datapath state that survives between items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            di_reg <= '0;
            qi_reg <= '0;
        end
        else
        begin
            case (cmd.wr)
                WR_CLEAR: begin di_reg <= '0; qi_reg <= '0; end
                WR_DI:    di_reg <= integ_d;
                WR_QI:    qi_reg <= integ_q;
                default:  di_reg <= di_reg;
            endcase
        end
    end

    // Payload registers updated by the sequencer.
    always_ff @(posedge clk)
    begin
        case (cmd.wr)
            WR_LOAD:
            begin
                alpha_reg <= signed'(item.phase_a_current);
                ab_reg    <= 18'(signed'(item.phase_a_current))
                           + (18'(signed'(item.phase_b_current)) <<< 1);
                idx_reg   <= item.electrical_angle[15 -: SINE_IDX_W];
                dref_reg  <= signed'(item.d_reference);
                qref_reg  <= signed'(item.q_reference);
                dt_reg    <= item.timestep;
                run_reg   <= item.run_enable && (item.timestep != 16'd0);
            end
            WR_SIN:      s_reg <= sine_lookup(idx_reg);
            WR_COS_BETA:
            begin
                c_reg    <= sine_lookup(idx_reg + SINE_IDX_W'(SINE_QTR));
                beta_reg <= 17'(rnd_shift(64'(mul_reg), 15));
            end
            WR_KIDT:     kidt_reg <= 40'(mul_reg);
            WR_ID:       id_reg <= sat_rnd15;
            WR_IQ_ED:
            begin
                iq_reg <= sat_rnd15;
                ed_reg <= err_d;
            end
            WR_EQ:       eq_reg <= err_q;
            WR_CLEAR:    begin vd_reg <= '0; vq_reg <= '0; end
            WR_VD:       vd_reg <= volt_d;
            WR_VQ:       vq_reg <= volt_q;
            WR_MAG:
            begin
                n_reg   <= acc64[31:0];
                res_reg <= '0;
            end
            WR_SQRT:
            begin
                if (n_reg >= sq_trial)
                begin
                    n_reg   <= n_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            WR_SQFIX:    m_reg <= 16'(res_reg) + 16'(n_reg != 32'd0);
            WR_NUMD:
            begin
                negd_reg <= mul_reg[MUL_P_W-1];
                remd_reg <= mul_reg[MUL_P_W-1] ? 31'(-mul_reg) : 31'(mul_reg);
            end
            WR_NUMQ:
            begin
                negq_reg <= mul_reg[MUL_P_W-1];
                remq_reg <= numq_mag[30:0];
                qd_reg   <= '0;
                qq_reg   <= '0;
            end
            WR_DIV:
            begin
                if (remd_reg >= dsh)
                begin
                    remd_reg <= remd_reg - dsh;
                    qd_reg   <= {qd_reg[14:0], 1'b1};
                end
                else
                begin
                    qd_reg   <= {qd_reg[14:0], 1'b0};
                end
                if (remq_reg >= dsh)
                begin
                    remq_reg <= remq_reg - dsh;
                    qq_reg   <= {qq_reg[14:0], 1'b1};
                end
                else
                begin
                    qq_reg   <= {qq_reg[14:0], 1'b0};
                end
            end
            WR_DFIN:
            begin
                vd_reg <= negd_reg ? -signed'(qd_reg) : signed'(qd_reg);
                vq_reg <= negq_reg ? -signed'(qq_reg) : signed'(qq_reg);
            end
            WR_OUT:
            begin
                out_reg.d_current <= id_reg;
                out_reg.q_current <= iq_reg;
                out_reg.d_voltage <= vd_reg;
                out_reg.q_voltage <= vq_reg;
            end
            default:     s_reg <= s_reg;
        endcase
    end

    assign result = out_reg;

endmodule

`default_nettype wire
